@@ sv/stamped_ring_fifo_assert.svh @@
// Assertion macros for the stamped ring FIFO checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef STAMPED_RING_FIFO_ASSERT_SVH
`define STAMPED_RING_FIFO_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define SRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that post holds in the cycle after pre.
`define SRF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ sv/srf_pkg.sv @@
// Shared types and constants of the stamped ring FIFO.
// No dependencies; imported by every module of the block.
package srf_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int SLICE_W     = 32;
  localparam int SEQ_W       = 32;
  localparam int STAMP_W     = 64;
  localparam int OCC_W       = 5;
  localparam int OVF_W       = 32;
  localparam int REQ_W       = 3;
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_TUSER_W = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 3'd0,
    REQ_TAKE  = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_DROP  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [SEQ_W-1:0]   seq;
    logic [SLICE_W-1:0] slice;
  } entry_t;

  typedef struct packed {
    logic             ok;
    logic             hit;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
    logic             is_full;
    logic [OVF_W-1:0] overflow_total;
  } status_t;

endpackage

@@ sv/stamped_ring_fifo.sv @@
// Top level of the stamped ring FIFO: input register, control, store, result.
// Depends on srf_pkg, srf_ctrl and srf_mem.
//
// Requests arrive on the s_axis channel: tdata carries slice_handle and
// stamp_ns, tuser carries req_type and slice_valid. Each request yields one
// result on the m_axis channel: tdata carries the head entry and the status
// after the request, tuser carries ok.
// A request accepted at one clock edge is held in the input register until
// the result register can advance; at that edge pointers move, the store is
// written and the head entry is read, and its result is valid after it.
// While results are taken, one request is taken every cycle; the rate is set
// by the single store access and pointer update per request.
// Reset empties the ring and clears the sequence number and the overflow
// count; entries are not cleared and reach the result only once written.
// When the receiver stalls, the result register holds and the input
// register fills; the channel then stops taking requests until the result
// is taken.
module stamped_ring_fifo #(
  parameter int DEPTH = srf_pkg::DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] slice_handle, [95:32] stamp_ns
  input  logic [srf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type, [3] slice_valid
  input  logic [srf_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] out_slice, [63:32] out_sequence, [127:64] out_stamp_ns,
  // [132:128] occupancy, [133] is_empty, [134] is_full,
  // [166:135] overflow_total, [167] zero
  output logic [srf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] ok
  output logic [srf_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import srf_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  logic               in_valid_q;
  req_e               in_req_q;
  logic               in_flag_q;
  logic [SLICE_W-1:0] in_slice_q;
  logic [STAMP_W-1:0] in_stamp_q;
  logic               out_valid_q;
  logic               adv, fire;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_slot, rd_slot;
  logic [SEQ_W-1:0]   wr_seq;
  entry_t             wr_data, rd_data, head;
  status_t            status;

  assign adv           = ~out_valid_q | m_axis_tready;
  assign fire          = in_valid_q & adv;
  assign s_axis_tready = ~in_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q   <= req_e'(s_axis_tuser[REQ_W-1:0]);
      in_flag_q  <= s_axis_tuser[REQ_W];
      in_slice_q <= s_axis_tdata[SLICE_W-1:0];
      in_stamp_q <= s_axis_tdata[SLICE_W+STAMP_W-1:SLICE_W];
    end
  end

  srf_ctrl #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .req_i        (in_req_q),
    .slice_valid_i(in_flag_q),
    .wr_en_o      (wr_en),
    .wr_slot_o    (wr_slot),
    .rd_slot_o    (rd_slot),
    .wr_seq_o     (wr_seq),
    .status_o     (status)
  );

  assign wr_data = '{stamp: in_stamp_q, seq: wr_seq, slice: in_slice_q};

  srf_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_slot_i(wr_slot),
    .wr_data_i(wr_data),
    .rd_en_i  (fire),
    .rd_slot_i(rd_slot),
    .rd_data_o(rd_data)
  );

  assign head          = status.hit ? rd_data : '0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status.ok;
  assign m_axis_tdata  = {1'b0, status.overflow_total, status.is_full, status.is_empty,
                          status.occupancy, head.stamp, head.seq, head.slice};

endmodule

@@ sv/srf_ctrl.sv @@
// Pointer, sequence and overflow control of the stamped ring FIFO.
// Depends on srf_pkg; drives the entry store and the registered status.
module srf_ctrl #(
  parameter int DEPTH  = srf_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  srf_pkg::req_e           req_i,
  input  logic                    slice_valid_i,
  output logic                    wr_en_o,
  output logic [ADDR_W-1:0]       wr_slot_o,
  output logic [ADDR_W-1:0]       rd_slot_o,
  output logic [srf_pkg::SEQ_W-1:0] wr_seq_o,
  output srf_pkg::status_t        status_o
);
  import srf_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ADDR_W-1:0] wslot_q, wslot_d, rslot_q, rslot_d;
  logic              wwrap_q, wwrap_d, rwrap_q, rwrap_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [OVF_W-1:0]  ovf_q, ovf_d;
  status_t           status_q, status_d;
  logic [CNT_W-1:0]  level_now, level_next;
  logic [OCC_W+CNT_W-1:0] level_wide;
  logic              push_en;

  function automatic logic [CNT_W-1:0] fill_level(input logic [ADDR_W-1:0] ws,
                                                  input logic wwp,
                                                  input logic [ADDR_W-1:0] rs,
                                                  input logic rwp);
    logic [CNT_W:0] t;
    if (wwp == rwp) begin
      t = (CNT_W+1)'(ws) - (CNT_W+1)'(rs);
    end else begin
      t = (CNT_W+1)'(DEPTH) + (CNT_W+1)'(ws) - (CNT_W+1)'(rs);
    end
    return t[CNT_W-1:0];
  endfunction

  assign level_now = fill_level(wslot_q, wwrap_q, rslot_q, rwrap_q);

  always_comb begin
    wslot_d  = wslot_q;
    wwrap_d  = wwrap_q;
    rslot_d  = rslot_q;
    rwrap_d  = rwrap_q;
    seq_d    = seq_q;
    ovf_d    = ovf_q;
    push_en  = 1'b0;
    status_d = '0;
    unique case (req_i) inside
      REQ_PUSH: begin
        if (slice_valid_i) begin
          if (level_now == CNT_W'(DEPTH)) begin
            if (ovf_q != '1) ovf_d = ovf_q + 1'b1;
          end else begin
            push_en     = 1'b1;
            status_d.ok = 1'b1;
            seq_d       = seq_q + 1'b1;
            if (wslot_q == ADDR_W'(DEPTH - 1)) begin
              wslot_d = '0;
              wwrap_d = ~wwrap_q;
            end else begin
              wslot_d = wslot_q + 1'b1;
            end
          end
        end
      end
      REQ_TAKE, REQ_PEEK, REQ_DROP: begin
        if (level_now != '0) begin
          status_d.ok  = 1'b1;
          status_d.hit = (req_i != REQ_DROP);
          if (req_i != REQ_PEEK) begin
            if (rslot_q == ADDR_W'(DEPTH - 1)) begin
              rslot_d = '0;
              rwrap_d = ~rwrap_q;
            end else begin
              rslot_d = rslot_q + 1'b1;
            end
          end
        end
      end
      REQ_CLEAR: begin
        wslot_d     = '0;
        wwrap_d     = 1'b0;
        rslot_d     = '0;
        rwrap_d     = 1'b0;
        seq_d       = '0;
        ovf_d       = '0;
        status_d.ok = 1'b1;
      end
      default: begin
      end
    endcase
    level_next              = fill_level(wslot_d, wwrap_d, rslot_d, rwrap_d);
    level_wide              = {{OCC_W{1'b0}}, level_next};
    status_d.occupancy      = level_wide[OCC_W-1:0];
    status_d.is_empty       = (level_next == '0);
    status_d.is_full        = (level_next == CNT_W'(DEPTH));
    status_d.overflow_total = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q  <= '0;
      wwrap_q  <= 1'b0;
      rslot_q  <= '0;
      rwrap_q  <= 1'b0;
      seq_q    <= '0;
      ovf_q    <= '0;
      status_q <= '0;
    end else if (fire_i) begin
      wslot_q  <= wslot_d;
      wwrap_q  <= wwrap_d;
      rslot_q  <= rslot_d;
      rwrap_q  <= rwrap_d;
      seq_q    <= seq_d;
      ovf_q    <= ovf_d;
      status_q <= status_d;
    end
  end

  assign wr_en_o   = fire_i & push_en;
  assign wr_slot_o = wslot_q;
  assign rd_slot_o = rslot_q;
  assign wr_seq_o  = seq_q;
  assign status_o  = status_q;

endmodule

@@ sv/srf_mem.sv @@
// Entry store of the stamped ring FIFO: one write port, one registered read.
// Depends on srf_pkg for the entry layout.
module srf_mem #(
  parameter int DEPTH  = srf_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_slot_i,
  input  srf_pkg::entry_t   wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_slot_i,
  output srf_pkg::entry_t   rd_data_o
);
  import srf_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_slot_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= mem_q[rd_slot_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/srf_checker.sv @@
// Port-level checks of the stamped ring FIFO result channel, bound to the top.
// Depends on srf_pkg and stamped_ring_fifo_assert.svh.
module srf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [srf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [srf_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import srf_pkg::*;
  `include "stamped_ring_fifo_assert.svh"

  `SRF_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `SRF_ASSERT(a_flags, !m_axis_tvalid || !(m_axis_tdata[133] && m_axis_tdata[134]), "empty and full together")
  `SRF_ASSERT(a_empty, !(m_axis_tvalid && m_axis_tdata[133]) || (m_axis_tdata[132:128] == '0), "empty with entries held")
  `SRF_ASSERT(a_zero, !(m_axis_tvalid && !m_axis_tuser[0]) || (m_axis_tdata[127:0] == '0), "refused request returned data")

endmodule

bind stamped_ring_fifo srf_checker u_srf_checker (.*);

@@ verif/tb.sv @@
// Testbench for stamped_ring_fifo: directed, random and back-pressure request streams.
// A predictor tracks the ring state and checks every result; needs srf_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import srf_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int PTR_MOD    = 2 * DEPTH;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 10;
  localparam int STALL_LEN  = 150;
  localparam int RANDOM_N   = 1000;
  localparam int MAX_SHOWN  = 40;

  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]   kind;
    logic [SLICE_W-1:0] handle;
    logic               valid;
    logic [STAMP_W-1:0] stamp;
  } ring_req_t;

  typedef struct {
    logic               ok;
    logic [SLICE_W-1:0] slice;
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] stamp;
    logic [OCC_W-1:0]   occ;
    logic               empty;
    logic               full;
    logic [OVF_W-1:0]   ovf;
  } ring_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  logic [SLICE_W-1:0] slice_mem [DEPTH];
  logic [SEQ_W-1:0]   seq_mem   [DEPTH];
  logic [STAMP_W-1:0] stamp_mem [DEPTH];
  int                 rd_ptr    = 0;
  int                 wr_ptr    = 0;
  logic [SEQ_W-1:0]   seq_next  = '0;
  logic [OVF_W-1:0]   ovf_count = '0;

  ring_result_t expected_q[$];
  int           mismatches   = 0;
  int           n_kind [8]   = '{default: 0};
  int           n_full_seen  = 0;
  int           n_overflowed = 0;
  logic         steady       = 1'b0;
  int           hold_req     = 0;
  int           hold_left    = 0;
  int           idle_cycles  = 0;

  stamped_ring_fifo #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic ring_result_t ring_apply(input ring_req_t rq);
    ring_result_t rs;
    int           level;
    int           slot;
    rs = '{default: '0};
    level = (wr_ptr + PTR_MOD - rd_ptr) % PTR_MOD;
    n_kind[rq.kind]++;
    case (rq.kind) inside
      REQ_PUSH: begin
        if (rq.valid) begin
          if (level >= DEPTH) begin
            n_overflowed++;
            if (ovf_count != '1) ovf_count++;
          end else begin
            slot            = wr_ptr % DEPTH;
            slice_mem[slot] = rq.handle;
            seq_mem[slot]   = seq_next;
            stamp_mem[slot] = rq.stamp;
            seq_next++;
            wr_ptr = (wr_ptr + 1) % PTR_MOD;
            rs.ok  = 1'b1;
          end
        end
      end
      REQ_TAKE, REQ_PEEK, REQ_DROP: begin
        if (level != 0) begin
          slot = rd_ptr % DEPTH;
          if (rq.kind != REQ_DROP) begin
            rs.slice = slice_mem[slot];
            rs.seq   = seq_mem[slot];
            rs.stamp = stamp_mem[slot];
          end
          if (rq.kind != REQ_PEEK) rd_ptr = (rd_ptr + 1) % PTR_MOD;
          rs.ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        rd_ptr    = 0;
        wr_ptr    = 0;
        seq_next  = '0;
        ovf_count = '0;
        rs.ok     = 1'b1;
      end
      default: ;
    endcase
    level    = (wr_ptr + PTR_MOD - rd_ptr) % PTR_MOD;
    rs.occ   = OCC_W'(level);
    rs.empty = (level == 0);
    rs.full  = (level == DEPTH);
    rs.ovf   = ovf_count;
    if (rs.full) n_full_seen++;
    return rs;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_SHOWN)
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : p_predict
    ring_req_t rq;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      rq.handle = s_axis_tdata[31:0];
      rq.stamp  = s_axis_tdata[95:32];
      rq.kind   = s_axis_tuser[2:0];
      rq.valid  = s_axis_tuser[3];
      expected_q.push_back(ring_apply(rq));
    end
  end

  always @(posedge clk_i) begin : p_check
    ring_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata[63:0], '0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tuser[0] !== want.ok)
          report_mismatch("ok", m_axis_tuser[0], want.ok);
        if (m_axis_tdata[31:0] !== want.slice)
          report_mismatch("out_slice", m_axis_tdata[31:0], want.slice);
        if (m_axis_tdata[63:32] !== want.seq)
          report_mismatch("out_sequence", m_axis_tdata[63:32], want.seq);
        if (m_axis_tdata[127:64] !== want.stamp)
          report_mismatch("out_stamp_ns", m_axis_tdata[127:64], want.stamp);
        if (m_axis_tdata[132:128] !== want.occ)
          report_mismatch("occupancy", m_axis_tdata[132:128], want.occ);
        if (m_axis_tdata[133] !== want.empty)
          report_mismatch("is_empty", m_axis_tdata[133], want.empty);
        if (m_axis_tdata[134] !== want.full)
          report_mismatch("is_full", m_axis_tdata[134], want.full);
        if (m_axis_tdata[166:135] !== want.ovf)
          report_mismatch("overflow_total", m_axis_tdata[166:135], want.ovf);
        if (m_axis_tdata[167] !== 1'b0)
          report_mismatch("pad bit", m_axis_tdata[167], '0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $realtime, IDLE_LIMIT);
      $display("[stamped_ring_fifo] ERROR");
      $finish;
    end
  end

  function automatic logic [STAMP_W-1:0] rand_stamp();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [SLICE_W-1:0] handle,
                          input logic valid, input logic [STAMP_W-1:0] stamp);
    if (!steady && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {stamp, handle};
    s_axis_tuser  <= {valid, kind};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic test_edge_cases();
    send_req(REQ_TAKE, '1, 1'b1, '1);
    send_req(REQ_PEEK, '1, 1'b1, '1);
    send_req(REQ_DROP, '0, 1'b0, '0);
    send_req(REQ_SPARE_LO, $urandom(), 1'b1, rand_stamp());
    send_req(REQ_SPARE_HI, $urandom(), 1'b0, rand_stamp());
    send_req(REQ_PUSH, '1, 1'b0, '1);
    send_req(REQ_PUSH, '0, 1'b1, '0);
    send_req(REQ_PUSH, '1, 1'b1, '1);
    for (int i = 2; i < DEPTH; i++) send_req(REQ_PUSH, $urandom(), 1'b1, rand_stamp());
    send_req(REQ_PUSH, $urandom(), 1'b1, rand_stamp());
    send_req(REQ_PUSH, $urandom(), 1'b1, rand_stamp());
    send_req(REQ_PUSH, $urandom(), 1'b0, rand_stamp());
    send_req(REQ_PEEK, '0, 1'b0, '0);
    send_req(REQ_TAKE, '0, 1'b0, '0);
    send_req(REQ_DROP, '1, 1'b1, '1);
    send_req(REQ_PUSH, $urandom(), 1'b1, rand_stamp());
    send_req(REQ_CLEAR, '1, 1'b1, '1);
    send_req(REQ_TAKE, '1, 1'b1, '1);
    send_req(REQ_PUSH, $urandom(), 1'b1, rand_stamp());
    send_req(REQ_TAKE, '0, 1'b0, '0);
  endtask

  task automatic test_random_traffic();
    int                 p;
    int                 push_pct;
    logic [REQ_W-1:0]   kind;
    logic               valid;
    logic [SLICE_W-1:0] handle;
    logic [STAMP_W-1:0] stamp;
    for (int i = 0; i < RANDOM_N; i++) begin
      steady   = (i >= 400 && i < 600);
      push_pct = ((i / 48) % 2 == 0) ? 70 : 25;
      p        = $urandom_range(99);
      valid    = 1'b1;
      handle   = $urandom();
      stamp    = rand_stamp();
      if ($urandom_range(19) == 0) begin
        handle = $urandom_range(1) ? '1 : '0;
        stamp  = $urandom_range(1) ? '1 : '0;
      end
      if (p < 3) begin
        kind  = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        valid = 1'($urandom_range(1));
      end else if (p < 5) begin
        kind  = REQ_CLEAR;
        valid = 1'($urandom_range(1));
      end else if (p < 9) begin
        kind  = REQ_PUSH;
        valid = 1'b0;
      end else if ($urandom_range(99) < push_pct) begin
        kind = REQ_PUSH;
      end else begin
        p     = $urandom_range(3);
        kind  = (p < 2) ? REQ_TAKE : ((p == 2) ? REQ_PEEK : REQ_DROP);
        valid = 1'($urandom_range(1));
      end
      send_req(kind, handle, valid, stamp);
    end
    steady = 1'b0;
  endtask

  task automatic test_output_stall();
    hold_req = STALL_LEN;
    for (int i = 0; i < 20; i++) send_req(REQ_PUSH, $urandom(), 1'b1, rand_stamp());
    for (int i = 0; i < 20; i++) send_req(REQ_TAKE, $urandom(), 1'b1, rand_stamp());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    wait_drain();
    test_random_traffic();
    wait_drain();
    test_output_stall();
    wait_drain();
    repeat (SETTLE) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("results never delivered", 64'(expected_q.size()), '0);
    $display("requests: %0d push, %0d take, %0d peek, %0d drop, %0d clear, %0d spare code",
             n_kind[REQ_PUSH], n_kind[REQ_TAKE], n_kind[REQ_PEEK], n_kind[REQ_DROP],
             n_kind[REQ_CLEAR], n_kind[5] + n_kind[6] + n_kind[7]);
    $display("ring reported full %0d times, %0d pushes refused on a full ring, %0d mismatches",
             n_full_seen, n_overflowed, mismatches);
    if (mismatches == 0)
      $display("[stamped_ring_fifo] OK");
    else
      $display("[stamped_ring_fifo] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/srf_pkg.sv
sv/srf_ctrl.sv
sv/srf_mem.sv
sv/stamped_ring_fifo.sv
sv/srf_checker.sv
verif/tb.sv
